### design/lds_pkg.sv
// ----------------------------------------------------------------------------
// lds_pkg
// shared types and constants for the linear diophantine solver
// ----------------------------------------------------------------------------
package lds_pkg;

  localparam int WIDTH = 32;
  // bezout coefficients need one bit more than the magnitudes
  localparam int CW    = WIDTH + 1;
  localparam int CNT_W = $clog2(WIDTH + 1);

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] rhs_c;
  } in_t;

  typedef struct packed {
    logic signed [31:0] sol_x;
    logic signed [31:0] sol_y;
    logic               solvable;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EUC_START,
    ST_EUC_WAIT,
    ST_MUL_U,
    ST_MUL_V,
    ST_UPDATE,
    ST_SCL_START,
    ST_SCL_WAIT,
    ST_MUL_X,
    ST_MUL_Y,
    ST_OUT
  } state_t;

endpackage

### design/lds_div.sv
// ----------------------------------------------------------------------------
// lds_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lds_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lds_pkg::WIDTH-1:0] dividend,
  input  logic [lds_pkg::WIDTH-1:0] divisor,
  output logic                      done,
  output logic [lds_pkg::WIDTH-1:0] quot,
  output logic [lds_pkg::WIDTH-1:0] rem
);

  logic                      busy_r, busy_nxt;
  logic [lds_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [lds_pkg::WIDTH-1:0] quo_r, quo_nxt;
  logic [lds_pkg::WIDTH-1:0] rem_r, rem_nxt;
  logic [lds_pkg::WIDTH-1:0] den_r, den_nxt;
  logic [lds_pkg::WIDTH:0]   shifted;
  logic [lds_pkg::WIDTH:0]   diff;

  assign shifted = {rem_r, quo_r[lds_pkg::WIDTH-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = lds_pkg::CNT_W'(lds_pkg::WIDTH);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      den_nxt  = divisor;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
        if (!diff[lds_pkg::WIDTH]) begin
          rem_nxt = diff[lds_pkg::WIDTH-1:0];
          quo_nxt = {quo_r[lds_pkg::WIDTH-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[lds_pkg::WIDTH-1:0];
          quo_nxt = {quo_r[lds_pkg::WIDTH-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = busy_r && (cnt_r == '0);
  assign quot = quo_r;
  assign rem  = rem_r;

endmodule

### design/linear_diophantine_solver.sv
// ----------------------------------------------------------------------------
// linear_diophantine_solver
// one integer solution of a*x + b*y = c by iterative extended euclid
// ----------------------------------------------------------------------------
// sequence: each euclid step runs a start, the shared divider, two
//   multiplies and an update; final scaling (a divide and, if it divides
//   evenly, two multiplies) follows before the result is offered; at most about 46 steps; a
//   both-zero input offers its result the cycle after acceptance
// one transaction at a time: no new input is taken until the result is taken
// reset: synchronous active-low rst_n returns the sequencer to idle with no
//   result pending
module linear_diophantine_solver (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  lds_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output lds_pkg::out_t  out_data
);

  lds_pkg::state_t state_r, state_nxt;

  // euclid remainders and bezout coefficients
  logic [lds_pkg::WIDTH-1:0]     r0_r, r0_nxt, r1_r, r1_nxt;
  logic signed [lds_pkg::CW-1:0] cu_r, cu_nxt, cv_r, cv_nxt;
  logic signed [lds_pkg::CW-1:0] nu_r, nu_nxt, nv_r, nv_nxt;
  // quotient and remainder of the current step
  logic [lds_pkg::WIDTH-1:0]     k_r, k_nxt, kr_r, kr_nxt;
  logic [lds_pkg::CW-1:0]        pu_r, pu_nxt, pv_r, pv_nxt;
  // signs of a, b and c, magnitude of c, and the scale factor c/g
  logic                          neg_a_r, neg_a_nxt, neg_b_r, neg_b_nxt;
  logic                          neg_c_r, neg_c_nxt;
  logic [lds_pkg::WIDTH-1:0]     cmag_r, cmag_nxt, s_r, s_nxt;
  lds_pkg::out_t                 res_r, res_nxt;

  // shared divider
  logic                      div_start, div_done;
  logic [lds_pkg::WIDTH-1:0] div_n, div_d, div_q, div_rm;

  // shared multiplier, low bits only (wrap-around arithmetic)
  logic [lds_pkg::CW-1:0]                mul_a;
  logic [lds_pkg::WIDTH-1:0]             mul_b;
  logic [lds_pkg::CW+lds_pkg::WIDTH-1:0] mul_full;
  logic [lds_pkg::CW-1:0]                mul_p;

  logic [lds_pkg::WIDTH-1:0] a_mag, b_mag, c_mag, x_low;

  assign mul_full = mul_a * mul_b;
  assign mul_p    = mul_full[lds_pkg::CW-1:0];
  assign x_low    = mul_p[lds_pkg::WIDTH-1:0];

  assign a_mag = in_data.coef_a[31] ? 32'(-in_data.coef_a) : in_data.coef_a;
  assign b_mag = in_data.coef_b[31] ? 32'(-in_data.coef_b) : in_data.coef_b;
  assign c_mag = in_data.rhs_c[31]  ? 32'(-in_data.rhs_c)  : in_data.rhs_c;

  lds_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rm)
  );

  always_comb begin
    state_nxt = state_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    cu_nxt    = cu_r;
    cv_nxt    = cv_r;
    nu_nxt    = nu_r;
    nv_nxt    = nv_r;
    k_nxt     = k_r;
    kr_nxt    = kr_r;
    pu_nxt    = pu_r;
    pv_nxt    = pv_r;
    neg_a_nxt = neg_a_r;
    neg_b_nxt = neg_b_r;
    neg_c_nxt = neg_c_r;
    cmag_nxt  = cmag_r;
    s_nxt     = s_r;
    res_nxt   = res_r;
    div_start = 1'b0;
    div_n     = r0_r;
    div_d     = r1_r;
    mul_a     = nu_r;
    mul_b     = k_r;

    case (state_r)
      lds_pkg::ST_IDLE: begin
        if (in_valid) begin
          neg_a_nxt = in_data.coef_a[31];
          neg_b_nxt = in_data.coef_b[31];
          neg_c_nxt = in_data.rhs_c[31];
          cmag_nxt  = c_mag;
          r0_nxt    = a_mag;
          r1_nxt    = b_mag;
          cu_nxt    = lds_pkg::CW'(1);
          cv_nxt    = '0;
          nu_nxt    = '0;
          nv_nxt    = lds_pkg::CW'(1);
          if (a_mag == '0 && b_mag == '0) begin
            // only c == 0 has a solution, namely zero
            res_nxt.sol_x    = '0;
            res_nxt.sol_y    = '0;
            res_nxt.solvable = (in_data.rhs_c == '0);
            state_nxt        = lds_pkg::ST_OUT;
          end else if (b_mag == '0) begin
            state_nxt = lds_pkg::ST_SCL_START;
          end else begin
            state_nxt = lds_pkg::ST_EUC_START;
          end
        end
      end
      lds_pkg::ST_EUC_START: begin
        div_start = 1'b1;
        state_nxt = lds_pkg::ST_EUC_WAIT;
      end
      lds_pkg::ST_EUC_WAIT: begin
        if (div_done) begin
          k_nxt     = div_q;
          kr_nxt    = div_rm;
          state_nxt = lds_pkg::ST_MUL_U;
        end
      end
      lds_pkg::ST_MUL_U: begin
        pu_nxt    = mul_p;
        state_nxt = lds_pkg::ST_MUL_V;
      end
      lds_pkg::ST_MUL_V: begin
        mul_a     = nv_r;
        pv_nxt    = mul_p;
        state_nxt = lds_pkg::ST_UPDATE;
      end
      lds_pkg::ST_UPDATE: begin
        // step the recurrence; coefficients stay within CW bits
        cu_nxt = nu_r;
        nu_nxt = cu_r - $signed(pu_r);
        cv_nxt = nv_r;
        nv_nxt = cv_r - $signed(pv_r);
        r0_nxt = r1_r;
        r1_nxt = kr_r;
        state_nxt = (kr_r == '0) ? lds_pkg::ST_SCL_START : lds_pkg::ST_EUC_START;
      end
      lds_pkg::ST_SCL_START: begin
        // |c| / g with g in r0
        div_start = 1'b1;
        div_n     = cmag_r;
        div_d     = r0_r;
        state_nxt = lds_pkg::ST_SCL_WAIT;
      end
      lds_pkg::ST_SCL_WAIT: begin
        div_n = cmag_r;
        div_d = r0_r;
        if (div_done) begin
          if (div_rm != '0) begin
            res_nxt.sol_x    = '0;
            res_nxt.sol_y    = '0;
            res_nxt.solvable = 1'b0;
            state_nxt        = lds_pkg::ST_OUT;
          end else begin
            s_nxt     = neg_c_r ? 32'(-div_q) : div_q;
            state_nxt = lds_pkg::ST_MUL_X;
          end
        end
      end
      lds_pkg::ST_MUL_X: begin
        mul_a         = cu_r;
        mul_b         = s_r;
        res_nxt.sol_x = neg_a_r ? 32'(-x_low) : x_low;
        state_nxt     = lds_pkg::ST_MUL_Y;
      end
      lds_pkg::ST_MUL_Y: begin
        mul_a            = cv_r;
        mul_b            = s_r;
        res_nxt.sol_y    = neg_b_r ? 32'(-x_low) : x_low;
        res_nxt.solvable = 1'b1;
        state_nxt        = lds_pkg::ST_OUT;
      end
      lds_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = lds_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lds_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    r0_r    <= r0_nxt;
    r1_r    <= r1_nxt;
    cu_r    <= cu_nxt;
    cv_r    <= cv_nxt;
    nu_r    <= nu_nxt;
    nv_r    <= nv_nxt;
    k_r     <= k_nxt;
    kr_r    <= kr_nxt;
    pu_r    <= pu_nxt;
    pv_r    <= pv_nxt;
    neg_a_r <= neg_a_nxt;
    neg_b_r <= neg_b_nxt;
    neg_c_r <= neg_c_nxt;
    cmag_r  <= cmag_nxt;
    s_r     <= s_nxt;
    res_r   <= res_nxt;
  end

  // busy from acceptance until the result transaction completes
  assign in_stall  = (state_r != lds_pkg::ST_IDLE);
  assign out_valid = (state_r == lds_pkg::ST_OUT);
  assign out_data  = res_r;

endmodule

### design/lds_checker.sv
// ----------------------------------------------------------------------------
// lds_checker
// port-level checks for the linear diophantine solver
// ----------------------------------------------------------------------------
module lds_port_assertions (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input lds_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input lds_pkg::out_t out_data
);

  // held result stays put while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a new transaction makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("not busy after accept");

  // no input taken while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> !out_valid)
    else $error("input accepted with result pending");

  // unsolvable results carry zero solutions
  a_zero_unsolv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.solvable |-> out_data.sol_x == '0 && out_data.sol_y == '0)
    else $error("nonzero solution on unsolvable result");

endmodule

bind linear_diophantine_solver lds_port_assertions u_lds_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
